// ----- rtl/core/crpm_pkg.sv -----
`timescale 1ns / 1ps

package crpm_pkg;

  localparam int unsigned MaxLinesDef = 15;
  localparam int unsigned FieldCount  = 5;
  localparam int unsigned BoundW      = 7;
  localparam int unsigned MaskW       = 15;
  localparam int unsigned CountOutW   = 4;

  typedef logic [BoundW-1:0] bound_t;

  typedef struct packed {
    bound_t [FieldCount-1:0] lo;
    bound_t [FieldCount-1:0] hi;
  } line_row_t;

  typedef struct packed {
    logic [2:0] field;
    logic [1:0] dash;
    logic       second;
    logic       star;
  } parse_t;

  typedef struct packed {
    logic line_inc;
    logic set_ovf;
    logic row_we;
  } byte_ctl_t;

  typedef enum logic [1:0] {
    KindByte    = 2'd0,
    KindTick    = 2'd1,
    KindRestart = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StByteRd,
    StByteWr,
    StTickRd,
    StTickCmp,
    StDone
  } state_e;

  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharNine    = 8'd57;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharDash    = 8'd45;
  localparam logic [7:0] CharStar    = 8'd42;
  localparam logic [7:0] CharNewline = 8'd10;

  localparam logic [2:0] FieldFirst = 3'd1;
  localparam logic [2:0] FieldLast  = 3'd5;
  localparam logic [2:0] FieldSat   = 3'd7;
  localparam logic [2:0] WeekdayIdx = 3'd4;
  localparam logic [1:0] DashSat    = 2'd3;

  localparam bound_t [FieldCount-1:0] FullLo = {7'd0, 7'd1, 7'd1, 7'd0, 7'd0};
  localparam bound_t [FieldCount-1:0] FullHi = {7'd6, 7'd12, 7'd31, 7'd23, 7'd59};

  localparam parse_t ParseReset = '{field: FieldFirst, dash: 2'd0, second: 1'b0, star: 1'b0};

endpackage

// ----- rtl/core/crpm_line_ram.sv -----
`timescale 1ns / 1ps

module crpm_line_ram #(
  parameter int unsigned Depth = crpm_pkg::MaxLinesDef,
  parameter int unsigned IdxW  = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [IdxW-1:0]         waddr_i,
  input  crpm_pkg::line_row_t     wdata_i,
  input  logic [IdxW-1:0]         raddr_i,
  output crpm_pkg::line_row_t     rdata_o
);
  import crpm_pkg::*;

  line_row_t              mem_q [Depth];
  logic      [Depth-1:0]  valid_q;
  line_row_t              rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

// ----- rtl/core/crpm_line_unit.sv -----
`timescale 1ns / 1ps

module crpm_line_unit (
  input  logic                                        have_line_i,
  input  logic [7:0]                                  char_i,
  input  crpm_pkg::parse_t                            ps_i,
  input  crpm_pkg::line_row_t                         row_i,
  input  crpm_pkg::bound_t [crpm_pkg::FieldCount-1:0] now_i,
  output crpm_pkg::parse_t                            ps_o,
  output crpm_pkg::line_row_t                         row_o,
  output crpm_pkg::byte_ctl_t                         ctl_o,
  output logic                                        hit_o
);
  import crpm_pkg::*;

  logic       in_fields;
  logic [2:0] fidx;
  bound_t     slot;
  bound_t     times10;
  bound_t     digit_val;
  logic [3:0] digit;

  always_comb begin
    in_fields = (ps_i.field >= FieldFirst) && (ps_i.field <= FieldLast);
    fidx      = in_fields ? 3'(ps_i.field - FieldFirst) : 3'd0;
    digit     = char_i[3:0];
    slot      = (ps_i.dash == 2'd0) ? row_i.lo[fidx] : row_i.hi[fidx];
    times10   = 7'({slot[3:0], 3'b000} + {slot[5:0], 1'b0});
    digit_val = ps_i.second ? 7'(times10 + {3'b000, digit}) : {3'b000, digit};

    row_o = row_i;
    ps_o  = ps_i;
    ctl_o = '0;

    priority if ((char_i >= CharZero) && (char_i <= CharNine)) begin
      if (in_fields && have_line_i && (ps_i.dash <= 2'd1)) begin
        ctl_o.row_we = 1'b1;
        ps_o.second  = !ps_i.second;
        if (ps_i.dash == 2'd0) begin
          row_o.lo[fidx] = digit_val;
          if (fidx == WeekdayIdx) begin
            row_o.hi[fidx] = digit_val;
          end
        end else begin
          row_o.hi[fidx] = digit_val;
        end
      end
    end else if (char_i == CharSpace) begin
      if (in_fields && (ps_i.dash == 2'd0) && !ps_i.star && have_line_i) begin
        ctl_o.row_we   = 1'b1;
        row_o.hi[fidx] = row_i.lo[fidx];
      end
      if (ps_i.field < FieldSat) begin
        ps_o.field = 3'(ps_i.field + 3'd1);
      end
      ps_o.dash   = 2'd0;
      ps_o.second = 1'b0;
      ps_o.star   = 1'b0;
    end else if (char_i == CharDash) begin
      if (in_fields) begin
        if (ps_i.dash < DashSat) begin
          ps_o.dash = 2'(ps_i.dash + 2'd1);
        end
        ps_o.second = 1'b0;
      end
    end else if (char_i == CharStar) begin
      if (in_fields) begin
        if ((ps_i.dash == 2'd0) && have_line_i) begin
          ctl_o.row_we   = 1'b1;
          row_o.lo[fidx] = FullLo[fidx];
          row_o.hi[fidx] = FullHi[fidx];
        end
        ps_o.star = 1'b1;
      end
    end else if (char_i == CharNewline) begin
      if (have_line_i) begin
        ctl_o.line_inc = 1'b1;
        ps_o           = ParseReset;
      end else begin
        ctl_o.set_ovf = 1'b1;
      end
    end else begin
      ps_o = ps_i;
    end

    hit_o = 1'b1;
    for (int f = 0; f < FieldCount; f++) begin
      if ((now_i[f] < row_i.lo[f]) || (now_i[f] > row_i.hi[f])) begin
        hit_o = 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/cron_range_parser_matcher.sv -----
`timescale 1ns / 1ps

// Cron schedule matcher. Crontab text is fed one byte per word (kind 0) and
// parsed into a table of schedule lines with low and high bounds per field.
// A tick word (kind 1) compares the current time with every loaded line and
// returns a match mask; a restart word (kind 2) empties the line count.
// A word is taken when start_i is high while busy_o is low. Every word yields
// exactly one result, shown for one cycle with done_o high, carrying the match
// mask, the number of loaded lines and the table full flag.
// A text byte passes through a read of the current line from the line memory,
// one update through the line unit with a write back, and the result cycle. A
// tick reads and checks the loaded lines in turn, up to 15 of them, since the
// line unit checks one line per memory read, and then gives its result. A
// restart or an unknown kind goes straight to the result. busy_o stays high
// until the result cycle ends. The receiver cannot stall results.
// Reset clears the line count, parse state and flags; line memory rows read as
// zero until first written.
module cron_range_parser_matcher #(
  parameter int unsigned MAX_LINES = crpm_pkg::MaxLinesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        kind_i,
  input  logic [7:0]                        char_code_i,
  input  logic [5:0]                        minute_i,
  input  logic [4:0]                        hour_i,
  input  logic [4:0]                        day_of_month_i,
  input  logic [3:0]                        month_i,
  input  logic [2:0]                        day_of_week_i,
  output logic                              done_o,
  output logic [crpm_pkg::MaskW-1:0]        match_mask_o,
  output logic [crpm_pkg::CountOutW-1:0]    lines_loaded_o,
  output logic                              table_full_o
);
  import crpm_pkg::*;

  localparam int unsigned IdxW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CntW = $clog2(MAX_LINES + 1);

  state_e                     state_q, state_d;
  logic   [7:0]               char_q, char_d;
  bound_t [FieldCount-1:0]    now_q, now_d;
  logic   [CntW-1:0]          line_q, line_d;
  logic   [CntW-1:0]          idx_q, idx_d;
  parse_t                     ps_q, ps_d;
  logic                       ovf_q, ovf_d;
  logic   [MaskW-1:0]         mask_q, mask_d;

  logic                       have_line;
  logic   [7:0]               line_ext;
  logic   [7:0]               idx_ext;
  logic   [7:0]               tick_lim;
  logic   [IdxW-1:0]          raddr;
  logic                       ram_we;
  line_row_t                  ram_rdata;
  line_row_t                  unit_row;
  parse_t                     unit_ps;
  byte_ctl_t                  unit_ctl;
  logic                       unit_hit;

  assign have_line = line_q < CntW'(MAX_LINES);
  assign line_ext  = 8'(line_q);
  assign idx_ext   = 8'(idx_q);
  assign tick_lim  = (line_ext < 8'd15) ? line_ext : 8'd15;
  assign raddr     = (state_q == StTickRd) ? idx_q[IdxW-1:0] : line_q[IdxW-1:0];
  assign ram_we    = (state_q == StByteWr) && unit_ctl.row_we;

  crpm_line_ram #(
    .Depth (MAX_LINES),
    .IdxW  (IdxW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (line_q[IdxW-1:0]),
    .wdata_i (unit_row),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  crpm_line_unit u_line_unit (
    .have_line_i (have_line),
    .char_i      (char_q),
    .ps_i        (ps_q),
    .row_i       (ram_rdata),
    .now_i       (now_q),
    .ps_o        (unit_ps),
    .row_o       (unit_row),
    .ctl_o       (unit_ctl),
    .hit_o       (unit_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      line_q  <= '0;
      idx_q   <= '0;
      ps_q    <= ParseReset;
      ovf_q   <= 1'b0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
      idx_q   <= idx_d;
      ps_q    <= ps_d;
      ovf_q   <= ovf_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    now_q  <= now_d;
  end

  always_comb begin
    state_d = state_q;
    char_d  = char_q;
    now_d   = now_q;
    line_d  = line_q;
    idx_d   = idx_q;
    ps_d    = ps_q;
    ovf_d   = ovf_q;
    mask_d  = mask_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          char_d = char_code_i;
          now_d  = {7'(day_of_week_i), 7'(month_i), 7'(day_of_month_i),
                    7'(hour_i), 7'(minute_i)};
          mask_d = '0;
          idx_d  = '0;
          unique case (kind_i)
            KindByte:    state_d = StByteRd;
            KindTick:    state_d = StTickRd;
            KindRestart: begin
              line_d  = '0;
              ovf_d   = 1'b0;
              ps_d    = ParseReset;
              state_d = StDone;
            end
            default:     state_d = StDone;
          endcase
        end
      end
      StByteRd: begin
        state_d = StByteWr;
      end
      StByteWr: begin
        ps_d = unit_ps;
        if (unit_ctl.line_inc) begin
          line_d = CntW'(line_q + 1'b1);
        end
        if (unit_ctl.set_ovf) begin
          ovf_d = 1'b1;
        end
        state_d = StDone;
      end
      StTickRd: begin
        if (idx_ext < tick_lim) begin
          state_d = StTickCmp;
        end else begin
          state_d = StDone;
        end
      end
      StTickCmp: begin
        if (unit_hit) begin
          mask_d[idx_ext[3:0]] = 1'b1;
        end
        idx_d   = CntW'(idx_q + 1'b1);
        state_d = StTickRd;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o         = state_q != StIdle;
  assign done_o         = state_q == StDone;
  assign match_mask_o   = mask_q;
  assign lines_loaded_o = line_ext[CountOutW-1:0];
  assign table_full_o   = ovf_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= CntW'(MAX_LINES))
    else $error("line count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (line_q == CntW'(MAX_LINES)))
    else $error("table full flag set while table has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTickCmp) |-> (idx_ext < tick_lim))
    else $error("match step past loaded lines");
`endif

endmodule

// ----- sim/cron_range_parser_matcher_tb.sv -----
`timescale 1ns / 1ps

module cron_range_parser_matcher_tb;
  import crpm_pkg::*;

  localparam int unsigned TableDepth  = MaxLinesDef;
  localparam int          WeekdayPos  = 4;
  localparam int          TotalWords  = 1800;
  localparam int          TailCycles  = 60;
  localparam int          CycleLimit  = 1000000;
  localparam int          ShowLimit   = 10;
  localparam logic [1:0]  KindUnknown = 2'd3;

  localparam int FieldLo [5] = '{0, 0, 1, 1, 0};
  localparam int FieldHi [5] = '{59, 23, 31, 12, 6};

  typedef struct {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [2:0] wday;
    int         idle_pct;
  } word_t;

  typedef struct packed {
    logic [MaskW-1:0]     mask;
    logic [CountOutW-1:0] lines;
    logic                 full;
  } status_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic [1:0]           kind_i         = '0;
  logic [7:0]           char_code_i    = '0;
  logic [5:0]           minute_i       = '0;
  logic [4:0]           hour_i         = '0;
  logic [4:0]           day_of_month_i = '0;
  logic [3:0]           month_i        = '0;
  logic [2:0]           day_of_week_i  = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [MaskW-1:0]     match_mask_o;
  logic [CountOutW-1:0] lines_loaded_o;
  logic                 table_full_o;

  word_t   pending_words [$];
  status_t expected_status [$];
  int      words_made     = 0;
  int      words_driven   = 0;
  int      words_taken    = 0;
  int      mismatch_count = 0;
  int      cycle_count    = 0;

  bound_t     low_tab  [TableDepth][5] = '{default: '0};
  bound_t     high_tab [TableDepth][5] = '{default: '0};
  logic [4:0] line_cnt       = '0;
  logic [2:0] field_pos      = FieldFirst;
  logic [1:0] dash_cnt       = '0;
  logic       second_pending = 1'b0;
  logic       star_seen      = 1'b0;
  logic       overflow       = 1'b0;

  cron_range_parser_matcher DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .minute_i       (minute_i),
    .hour_i         (hour_i),
    .day_of_month_i (day_of_month_i),
    .month_i        (month_i),
    .day_of_week_i  (day_of_week_i),
    .done_o         (done_o),
    .match_mask_o   (match_mask_o),
    .lines_loaded_o (lines_loaded_o),
    .table_full_o   (table_full_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_parse_state();
    field_pos      = FieldFirst;
    dash_cnt       = '0;
    second_pending = 1'b0;
    star_seen      = 1'b0;
  endfunction

  // Applies one word to the schedule table and returns the status it reports.
  function automatic status_t crontab_step(word_t w);
    status_t res;
    bound_t  val;
    int      f;
    int      d;
    logic    in_fields;
    logic    hit;
    int      now [5];
    res.mask  = '0;
    f         = int'(field_pos) - 1;
    in_fields = field_pos >= FieldFirst && field_pos <= FieldLast;
    case (w.kind)
      KindByte: begin
        if (w.ch >= CharZero && w.ch <= CharNine) begin
          if (in_fields && line_cnt < TableDepth && dash_cnt <= 2'd1) begin
            d   = int'(w.ch - CharZero);
            val = (dash_cnt == 2'd0) ? low_tab[line_cnt][f] : high_tab[line_cnt][f];
            if (!second_pending) begin
              val            = bound_t'(d);
              second_pending = 1'b1;
            end else begin
              val            = bound_t'(int'(val) * 10 + d);
              second_pending = 1'b0;
            end
            if (dash_cnt == 2'd0) begin
              low_tab[line_cnt][f] = val;
              if (f == WeekdayPos) high_tab[line_cnt][f] = val;
            end else begin
              high_tab[line_cnt][f] = val;
            end
          end
        end else if (w.ch == CharSpace) begin
          if (in_fields && dash_cnt == 2'd0 && !star_seen && line_cnt < TableDepth)
            high_tab[line_cnt][f] = low_tab[line_cnt][f];
          if (field_pos < FieldSat) field_pos++;
          dash_cnt       = '0;
          second_pending = 1'b0;
          star_seen      = 1'b0;
        end else if (w.ch == CharDash) begin
          if (in_fields) begin
            if (dash_cnt < DashSat) dash_cnt++;
            second_pending = 1'b0;
          end
        end else if (w.ch == CharStar) begin
          if (in_fields) begin
            if (dash_cnt == 2'd0 && line_cnt < TableDepth) begin
              low_tab[line_cnt][f]  = bound_t'(FieldLo[f]);
              high_tab[line_cnt][f] = bound_t'(FieldHi[f]);
            end
            star_seen = 1'b1;
          end
        end else if (w.ch == CharNewline) begin
          if (line_cnt >= TableDepth) begin
            overflow = 1'b1;
          end else begin
            clear_parse_state();
            line_cnt++;
          end
        end
      end
      KindTick: begin
        now = '{int'(w.minute), int'(w.hour), int'(w.mday), int'(w.month), int'(w.wday)};
        for (int i = 0; i < line_cnt; i++) begin
          hit = 1'b1;
          for (int j = 0; j < 5; j++) begin
            if (now[j] < int'(low_tab[i][j]) || now[j] > int'(high_tab[i][j])) hit = 1'b0;
          end
          res.mask[i] = hit;
        end
      end
      KindRestart: begin
        line_cnt = '0;
        overflow = 1'b0;
        clear_parse_state();
      end
      default: begin
      end
    endcase
    res.lines = line_cnt[CountOutW-1:0];
    res.full  = overflow;
    return res;
  endfunction

  task automatic push_word(logic [1:0] kind, logic [7:0] ch);
    word_t w;
    w.kind   = kind;
    w.ch     = ch;
    w.minute = 6'($urandom);
    w.hour   = 5'($urandom);
    w.mday   = 5'($urandom);
    w.month  = 4'($urandom);
    w.wday   = 3'($urandom);
    case ((words_made / 150) % 3)
      0:       w.idle_pct = 0;
      1:       w.idle_pct = 73;
      default: w.idle_pct = 10;
    endcase
    pending_words.push_back(w);
    words_made++;
  endtask

  task automatic push_byte(logic [7:0] ch);
    push_word(KindByte, ch);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_number(int v);
    if (v < 10 && $urandom_range(3) == 0) push_byte(CharZero);
    push_text($sformatf("%0d", v));
  endtask

  task automatic push_tick(logic [5:0] mn, logic [4:0] hr, logic [4:0] dm, logic [3:0] mo,
                           logic [2:0] dw);
    push_word(KindTick, 8'($urandom));
    pending_words[$].minute = mn;
    pending_words[$].hour   = hr;
    pending_words[$].mday   = dm;
    pending_words[$].month  = mo;
    pending_words[$].wday   = dw;
  endtask

  task automatic push_random_tick();
    if ($urandom_range(4) == 0)
      push_tick(6'($urandom), 5'($urandom), 5'($urandom), 4'($urandom), 3'($urandom));
    else
      push_tick(6'($urandom_range(59)), 5'($urandom_range(23)), 5'($urandom_range(31, 1)),
                4'($urandom_range(12, 1)), 3'($urandom_range(6)));
  endtask

  task automatic push_field(int f);
    int lo;
    int hi;
    lo = FieldLo[f];
    hi = FieldHi[f];
    case ($urandom_range(9))
      0, 1, 2: push_byte(CharStar);
      3, 4, 5: push_number($urandom_range(hi, lo));
      6, 7, 8: begin
        push_number($urandom_range(hi, lo));
        push_byte(CharDash);
        push_number($urandom_range(hi, lo));
      end
      default: begin
        case ($urandom_range(3))
          0: push_number($urandom_range(999));
          1: begin
            push_number($urandom_range(hi, lo));
            repeat ($urandom_range(3, 2)) push_byte(CharDash);
            push_number($urandom_range(99));
          end
          2: begin
            push_byte(CharDash);
            push_byte(CharStar);
            push_number($urandom_range(99));
          end
          default: begin
            push_number($urandom_range(9));
            push_byte(CharStar);
            push_number($urandom_range(9));
          end
        endcase
      end
    endcase
  endtask

  task automatic push_line(int nfields);
    for (int f = 0; f < nfields; f++) begin
      push_field(f);
      if (f < nfields - 1) push_byte(CharSpace);
    end
    if (nfields == 5 && $urandom_range(2) == 0) push_text(" run 12-3 * job");
    push_byte(CharNewline);
  endtask

  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (!(start_i && words_taken != words_driven)) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= pending_words[0].idle_pct) begin
          w = pending_words.pop_front();
          start_i        <= 1'b1;
          kind_i         <= w.kind;
          char_code_i    <= w.ch;
          minute_i       <= w.minute;
          hour_i         <= w.hour;
          day_of_month_i <= w.mday;
          month_i        <= w.month;
          day_of_week_i  <= w.wday;
          words_driven++;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    status_t want;
    word_t   seen;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_status.size() == 0) begin
          if (mismatch_count < ShowLimit)
            $display("%0t: result with no word outstanding: mask %h lines %0d full %0d",
                     $realtime, match_mask_o, lines_loaded_o, table_full_o);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          if (want.mask !== match_mask_o || want.lines !== lines_loaded_o ||
              want.full !== table_full_o) begin
            if (mismatch_count < ShowLimit)
              $display("%0t: mismatch: mask exp %h got %h, lines exp %0d got %0d, full exp %0d got %0d",
                       $realtime, want.mask, match_mask_o, want.lines, lines_loaded_o,
                       want.full, table_full_o);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        seen.kind     = kind_i;
        seen.ch       = char_code_i;
        seen.minute   = minute_i;
        seen.hour     = hour_i;
        seen.mday     = day_of_month_i;
        seen.month    = month_i;
        seen.wday     = day_of_week_i;
        seen.idle_pct = 0;
        expected_status.push_back(crontab_step(seen));
        words_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    push_tick('0, '0, '0, '0, '0);
    push_word(KindUnknown, 8'hFF);
    push_text("* * 1-5 * 6\n");
    push_tick('1, '1, '1, '1, '1);
    push_tick(6'd0, 5'd0, 5'd1, 4'd1, 3'd0);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_word(KindRestart, 8'h00);
    push_tick(6'd59, 5'd23, 5'd31, 4'd12, 3'd6);
    push_text("--9\n");

    while (words_made < TotalWords) begin
      case ($urandom_range(99)) inside
        [0:49]: begin
          push_line(5);
          repeat ($urandom_range(2)) push_random_tick();
        end
        [50:67]: push_random_tick();
        [68:77]: begin
          repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(5))
              0:       push_byte(8'(CharZero + $urandom_range(9)));
              1:       push_byte(CharSpace);
              2:       push_byte(CharDash);
              3:       push_byte(CharStar);
              4:       push_byte(CharNewline);
              default: push_byte(8'($urandom));
            endcase
          end
        end
        [78:80]: push_word(KindRestart, 8'($urandom));
        [81:82]: push_word(KindUnknown, 8'($urandom));
        [83:89]: repeat ($urandom_range(16, 1)) push_byte(CharNewline);
        default: push_line($urandom_range(4, 1));
      endcase
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || words_taken != words_driven ||
           expected_status.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
